>>> design/hdm_pkg.sv
// Shared types, widths and helper functions for the holonomic drive mixer.
package hdm_pkg;

  // Field widths of one drive command and one wheel result
  localparam int NUM_WHEELS = 4;
  localparam int SPEED_BITS = 8;
  localparam int LEVEL_W    = SPEED_BITS;
  localparam int HEAD_W     = 2;
  localparam int FWD_W      = LEVEL_W + 1;
  localparam int DIR_W      = 2;

  // Mixed speed needs room for three summed terms; magnitude is one bit narrower
  localparam int MIX_W  = LEVEL_W + 3;
  localparam int MAG_W  = LEVEL_W + 2;
  localparam int PROD_W = LEVEL_W + MAG_W;

  // Stream widths, rounded up to whole bytes
  localparam int CMD_BITS = HEAD_W + FWD_W + 2 * (DIR_W + LEVEL_W);
  localparam int IN_W     = ((CMD_BITS + 7) / 8) * 8;
  localparam int RES_BITS = NUM_WHEELS * (LEVEL_W + 1);
  localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEVEL_W-1:0] FULL_SPEED_RESET = LEVEL_W'(255);

  // Input command, first field in the lowest bits
  typedef struct packed {
    logic [IN_W-CMD_BITS-1:0] pad;
    logic [LEVEL_W-1:0]       turn_speed;
    logic [DIR_W-1:0]         turn_dir;
    logic [LEVEL_W-1:0]       side_speed;
    logic [DIR_W-1:0]         side_dir;
    logic [FWD_W-1:0]         forward_speed;
    logic [HEAD_W-1:0]        heading;
  } hdm_cmd_t;

  // Classified work item, already rotated onto physical motors
  typedef struct packed {
    logic [LEVEL_W-1:0]                   full;
    logic [MAG_W-1:0]                     div;
    logic [NUM_WHEELS-1:0][PROD_W-1:0]    prod;
    logic [NUM_WHEELS-1:0]                rev;
  } hdm_job_t;

  // One stage of the divider pipeline
  typedef struct packed {
    logic [LEVEL_W-1:0]                   full;
    logic [MAG_W-1:0]                     div;
    logic [NUM_WHEELS-1:0][PROD_W-1:0]    rem;
    logic [NUM_WHEELS-1:0][LEVEL_W-1:0]   quo;
    logic [NUM_WHEELS-1:0]                rev;
  } hdm_stage_t;

  // Finished result handed to the output port
  typedef struct packed {
    logic [LEVEL_W-1:0]                   full;
    logic [NUM_WHEELS-1:0][LEVEL_W-1:0]   lvl;
    logic [NUM_WHEELS-1:0]                rev;
  } hdm_result_t;

  // Signed term from a direction code and a speed; any negative code means reverse
  function automatic logic signed [MIX_W-1:0] hdm_signed_speed(
    input logic [DIR_W-1:0]   dir,
    input logic [LEVEL_W-1:0] spd
  );
    logic signed [MIX_W-1:0] s;
    s = MIX_W'(spd);
    if (dir[DIR_W-1]) begin
      return -s;
    end else if (dir[0]) begin
      return s;
    end
    return '0;
  endfunction

  // Magnitude of a mixed speed; its range always fits MAG_W bits
  function automatic logic [MAG_W-1:0] hdm_abs(input logic signed [MIX_W-1:0] v);
    logic [MIX_W-1:0] a;
    a = v[MIX_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // One restoring-division step on all lanes: quotient bit at weight 2**sh
  function automatic hdm_stage_t hdm_div_step(input hdm_stage_t x, input int unsigned sh);
    hdm_stage_t        y;
    logic [PROD_W-1:0] dsh;
    logic              take;
    y   = x;
    dsh = PROD_W'(x.div) << sh;
    for (int k = 0; k < NUM_WHEELS; k++) begin
      take = (x.rem[k] >= dsh);
      if (take) begin
        y.rem[k] = x.rem[k] - dsh;
      end
      y.quo[k] = {x.quo[k][LEVEL_W-2:0], take};
    end
    return y;
  endfunction

endpackage

>>> design/hdm_front.sv
// Front end: takes commands, mixes wheel speeds, finds the maximum and rotates roles.
module hdm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hdm_pkg::IN_W-1:0]          s_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hdm_pkg::LEVEL_W-1:0]       cfg_data,
  output logic                              job_valid,
  input  logic                              job_ready,
  output hdm_pkg::hdm_job_t                 job
);

  localparam int NW = hdm_pkg::NUM_WHEELS;

  logic [hdm_pkg::LEVEL_W-1:0]        full_speed;
  hdm_pkg::hdm_cmd_t                  cmd;
  logic signed [hdm_pkg::MIX_W-1:0]   fwd;
  logic signed [hdm_pkg::MIX_W-1:0]   side;
  logic signed [hdm_pkg::MIX_W-1:0]   turn;
  logic signed [hdm_pkg::MIX_W-1:0]   v [NW];
  logic [hdm_pkg::MAG_W-1:0]          mag [NW];
  logic [hdm_pkg::PROD_W-1:0]         prod [NW];
  logic [hdm_pkg::MAG_W-1:0]          mx01;
  logic [hdm_pkg::MAG_W-1:0]          mx23;
  logic [hdm_pkg::MAG_W-1:0]          mx;
  logic [hdm_pkg::HEAD_W-1:0]         role [NW];
  hdm_pkg::hdm_job_t                  job_next;

  // Full-speed register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_speed <= hdm_pkg::FULL_SPEED_RESET;
    end else if (cfg_valid) begin
      full_speed <= cfg_data;
    end
  end

  // Mix the command into the four wheel roles LF, RF, RB, LB
  assign cmd  = hdm_pkg::hdm_cmd_t'(s_tdata);
  assign fwd  = {{(hdm_pkg::MIX_W - hdm_pkg::FWD_W){cmd.forward_speed[hdm_pkg::FWD_W-1]}},
                 cmd.forward_speed};
  assign side = hdm_pkg::hdm_signed_speed(cmd.side_dir, cmd.side_speed);
  assign turn = hdm_pkg::hdm_signed_speed(cmd.turn_dir, cmd.turn_speed);

  assign v[0] = -fwd - side - turn;
  assign v[1] =  fwd - side - turn;
  assign v[2] =  fwd + side - turn;
  assign v[3] = -fwd + side - turn;

  // Magnitudes, scaled numerators and the largest magnitude
  always_comb begin
    for (int k = 0; k < NW; k++) begin
      mag[k]  = hdm_pkg::hdm_abs(v[k]);
      prod[k] = hdm_pkg::PROD_W'(full_speed) * hdm_pkg::PROD_W'(mag[k]);
    end
    mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
    mx   = (mx01 > mx23) ? mx01 : mx23;
  end

  // Rotate roles onto motors; all-stopped divides zero by one and gives zero
  always_comb begin
    job_next.full = full_speed;
    job_next.div  = (mx == '0) ? hdm_pkg::MAG_W'(1) : mx;
    for (int m = 0; m < NW; m++) begin
      role[m]          = hdm_pkg::HEAD_W'(m) - cmd.heading;
      job_next.prod[m] = prod[role[m]];
      job_next.rev[m]  = v[role[m]][hdm_pkg::MIX_W-1];
    end
  end

  // Output register toward the queue
  assign s_tready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s_tready) begin
      job_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      job <= job_next;
    end
  end

endmodule

>>> design/hdm_queue.sv
// Small FIFO of classified work items between the front end and the divider.
module hdm_queue #(
  parameter int DEPTH = hdm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hdm_pkg::hdm_job_t in_job,
  output logic              out_valid,
  input  logic              out_ready,
  output hdm_pkg::hdm_job_t out_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hdm_pkg::hdm_job_t  slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/hdm_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage on all four lanes.
module hdm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  hdm_pkg::hdm_job_t    job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hdm_pkg::hdm_result_t out_res
);

  localparam int NS = hdm_pkg::LEVEL_W;

  hdm_pkg::hdm_stage_t st [NS];
  logic                vld [NS];
  hdm_pkg::hdm_stage_t first;
  logic                adv;

  // Whole pipeline moves unless the finished result is held
  assign adv       = !vld[NS-1] || out_ready;
  assign job_ready = adv;

  // Stage-zero operands straight from the queue head
  always_comb begin
    first.full = job.full;
    first.div  = job.div;
    first.rem  = job.prod;
    first.quo  = '0;
    first.rev  = job.rev;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    hdm_pkg::hdm_stage_t src;
    logic                src_vld;

    if (s == 0) begin : g_head
      assign src     = first;
      assign src_vld = job_valid;
    end else begin : g_body
      assign src     = st[s-1];
      assign src_vld = vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[s] <= hdm_pkg::hdm_div_step(src, NS - 1 - s);
      end
    end
  end

  // Last stage is the output register
  assign out_valid   = vld[NS-1];
  assign out_res.full = st[NS-1].full;
  assign out_res.lvl  = st[NS-1].quo;
  assign out_res.rev  = st[NS-1].rev;

endmodule

>>> design/holonomic_drive_mixer.sv
// Top level of the four-wheel omni drive mixer: front end, queue, divider, output packing.

// Takes one drive command per transaction and returns one transaction with
// direction and level for the four physical motors. A new command can be
// taken every clock cycle while the queue is not full. A command passes
// through the mixing front-end register, a queue slot and the stages of
// the divider pipeline, which resolves one bit of each wheel's level per
// stage. The queue (QUEUE_DEPTH entries) lets the front end keep taking
// commands while the output side is stalled, until the queue fills.
// full_speed is set through the cfg channel, is always ready and should be
// changed only while no command is in flight; it resets to 255. When every
// mixed wheel speed is zero all motors report forward at level zero.
module holonomic_drive_mixer #(
  parameter int QUEUE_DEPTH = hdm_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // heading, forward_speed, side_dir, side_speed, turn_dir, turn_speed
  input  logic [hdm_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // motor0_reverse, motor0_level, motor1_reverse, motor1_level,
  // motor2_reverse, motor2_level, motor3_reverse, motor3_level
  output logic [hdm_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hdm_pkg::LEVEL_W-1:0] cfg_data
);

  localparam int NW  = hdm_pkg::NUM_WHEELS;
  localparam int LW  = hdm_pkg::LEVEL_W;

  logic                 f_valid;
  logic                 f_ready;
  hdm_pkg::hdm_job_t    f_job;
  logic                 q_valid;
  logic                 q_ready;
  hdm_pkg::hdm_job_t    q_job;
  hdm_pkg::hdm_result_t res;

  hdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  hdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  hdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack motor fields, motor 0 in the lowest bits
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < NW; k++) begin
      m_tdata[k*(LW+1) +: (LW+1)] = {res.lvl[k], res.rev[k]};
    end
  end

  // A taken command always lands in the front-end register
  a_front_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> f_valid)
    else $error("accepted command did not reach front-end register");

  // Fastest wheel reaches full speed unless everything is stopped
  a_full_reached: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.lvl[0] == res.full) || (res.lvl[1] == res.full) ||
                 (res.lvl[2] == res.full) || (res.lvl[3] == res.full) ||
                 ((res.lvl == '0) && (res.rev == '0)))
    else $error("no wheel scaled to full speed");

  // All-stopped result never reports a reverse motor
  a_stop_forward: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.full != '0) && (res.lvl == '0) |-> (res.rev == '0))
    else $error("stopped result carries a reverse bit");

endmodule
